FILE: design/prsd_pkg.sv
package prsd_pkg;

  localparam int DEF_PALETTE_DEPTH = 128;
  localparam int SIZE_W = 7;

  localparam logic [7:0]  RUN_ESC8  = 8'hFF;
  localparam logic [15:0] RUN_ESC16 = 16'hFFFF;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_COUNT = 3'd1;
  localparam logic [2:0] ST_BAD_INDEX = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_SHORT     = 3'd4;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [6:0] {
    PH_COUNT   = 7'b0000001,
    PH_PALETTE = 7'b0000010,
    PH_HEADER  = 7'b0000100,
    PH_RUN8    = 7'b0001000,
    PH_RUN16   = 7'b0010000,
    PH_RUN32   = 7'b0100000,
    PH_SKIP    = 7'b1000000
  } phase_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHK   = 6'b000010,
    S_RUN   = 6'b000100,
    S_SCHK  = 6'b001000,
    S_SUITE = 6'b010000,
    S_STAT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [23:0] color;
    logic [31:0] rep;
    logic [31:0] start;
    logic        is_status;
    logic [2:0]  code;
    logic        last;
  } res_t;

  // bit length of (count - 1), at least 1
  function automatic logic [2:0] index_bits(input logic [SIZE_W-1:0] count);
    logic [SIZE_W-1:0] v;
    logic [2:0]        nb;
    v  = count - 1'b1;
    nb = 3'd1;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) begin
        nb = 3'(i + 1);
      end
    end
    return nb;
  endfunction

endpackage

FILE: design/prsd_pal_ram.sv
module prsd_pal_ram
  import prsd_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
  parameter int AW = $clog2(PALETTE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata_r
);

  logic [23:0] mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: design/prsd_out_buf.sv
module prsd_out_buf
  import prsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t res,
  output logic can_take,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r;
  res_t q_r;

  assign can_take  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r <= res;
    end
  end

endmodule

FILE: design/prsd_ctrl.sv
module prsd_ctrl
  import prsd_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
  parameter int AW = $clog2(PALETTE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_data,
  input  logic          in_last,
  output logic          in_ready,
  input  logic [31:0]   total,
  output logic          pal_we,
  output logic [AW-1:0] pal_waddr,
  output logic [23:0]   pal_wdata,
  output logic          pal_re,
  output logic [AW-1:0] pal_raddr,
  input  logic [23:0]   pal_rdata,
  output logic          push,
  output res_t          res,
  input  logic          can_take
);

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [2:0]        nb_r, nb_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [1:0]        sub_r, sub_nxt;
  logic [7:0]        blue_r, blue_nxt;
  logic [7:0]        green_r, green_nxt;
  logic [7:0]        hdr_r, hdr_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic [31:0]       run_r, run_nxt;
  logic [31:0]       pix_r, pix_nxt;
  logic [2:0]        err_r, err_nxt;
  logic              last_r, last_nxt;
  logic [AW-1:0]     start_r, start_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [6:0]        depth_r, depth_nxt;
  logic [6:0]        cnt_r, cnt_nxt;

  logic        fin;
  logic [15:0] val16;
  logic [7:0]  stop8, depth8, start8;
  logic [32:0] run_end, suite_end, total33;
  state_t      after;

  assign in_ready = (state_r == S_IDLE);
  assign after    = last_r ? S_STAT : S_IDLE;
  assign val16    = {in_data, run_r[7:0]};
  assign stop8    = hdr_r & (8'hFF >> (4'd8 - {1'b0, nb_r}));
  assign depth8   = hdr_r >> nb_r;
  assign start8   = stop8 - depth8;
  assign total33  = {1'b0, total};
  assign run_end  = {1'b0, pix_r} + {1'b0, run_r};
  assign suite_end = {1'b0, pix_r} + 33'(depth_r) + 33'd1;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    size_nxt  = size_r;
    nb_nxt    = nb_r;
    idx_nxt   = idx_r;
    sub_nxt   = sub_r;
    blue_nxt  = blue_r;
    green_nxt = green_r;
    hdr_nxt   = hdr_r;
    pos_nxt   = pos_r;
    run_nxt   = run_r;
    pix_nxt   = pix_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    start_nxt = start_r;
    ptr_nxt   = ptr_r;
    depth_nxt = depth_r;
    cnt_nxt   = cnt_r;
    fin       = 1'b0;
    pal_we    = 1'b0;
    pal_waddr = idx_r;
    pal_wdata = {in_data, green_r, blue_r};
    pal_re    = 1'b0;
    pal_raddr = start_r;
    push      = 1'b0;
    res       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last;
          case (phase_r)
            PH_COUNT: begin
              if (in_data == 8'd0 || in_data > 8'(PALETTE_DEPTH - 1)) begin
                err_nxt   = ST_BAD_COUNT;
                phase_nxt = PH_SKIP;
              end else begin
                size_nxt  = in_data[SIZE_W-1:0];
                nb_nxt    = index_bits(in_data[SIZE_W-1:0]);
                idx_nxt   = '0;
                sub_nxt   = 2'd0;
                phase_nxt = PH_PALETTE;
              end
            end
            PH_PALETTE: begin
              if (sub_r == 2'd0) begin
                blue_nxt = in_data;
                sub_nxt  = 2'd1;
              end else if (sub_r == 2'd1) begin
                green_nxt = in_data;
                sub_nxt   = 2'd2;
              end else begin
                pal_we  = 1'b1;
                sub_nxt = 2'd0;
                idx_nxt = idx_r + 1'b1;
                if (SIZE_W'(idx_r) == size_r - 1'b1) begin
                  phase_nxt = PH_HEADER;
                end
              end
            end
            PH_HEADER: begin
              hdr_nxt   = in_data;
              phase_nxt = PH_RUN8;
            end
            PH_RUN8: begin
              if (in_data == RUN_ESC8) begin
                run_nxt   = '0;
                pos_nxt   = 2'd0;
                phase_nxt = PH_RUN16;
              end else begin
                run_nxt   = {24'd0, in_data};
                phase_nxt = PH_HEADER;
                fin       = 1'b1;
              end
            end
            PH_RUN16: begin
              if (pos_r == 2'd0) begin
                run_nxt = {24'd0, in_data};
                pos_nxt = 2'd1;
              end else if (val16 == RUN_ESC16) begin
                run_nxt   = '0;
                pos_nxt   = 2'd0;
                phase_nxt = PH_RUN32;
              end else begin
                run_nxt   = {16'd0, val16};
                pos_nxt   = 2'd0;
                phase_nxt = PH_HEADER;
                fin       = 1'b1;
              end
            end
            PH_RUN32: begin
              run_nxt[{pos_r, 3'b000} +: 8] = in_data;
              pos_nxt = pos_r + 2'd1;
              if (pos_r == 2'd3) begin
                phase_nxt = PH_HEADER;
                fin       = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (fin) begin
            state_nxt = S_CHK;
          end else if (in_last) begin
            state_nxt = S_STAT;
          end
        end
      end
      S_CHK: begin
        if (start8 >= {1'b0, size_r} || stop8 >= {1'b0, size_r}) begin
          err_nxt   = ST_BAD_INDEX;
          phase_nxt = PH_SKIP;
          state_nxt = after;
        end else if (run_end > total33) begin
          err_nxt   = ST_OVERFLOW;
          phase_nxt = PH_SKIP;
          state_nxt = after;
        end else begin
          pal_re    = 1'b1;
          pal_raddr = AW'(start8);
          start_nxt = AW'(start8);
          depth_nxt = depth8[6:0];
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (can_take) begin
          push      = 1'b1;
          res.color = pal_rdata;
          res.rep   = run_r;
          res.start = pix_r;
          pix_nxt   = pix_r + run_r;
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (suite_end > total33) begin
          err_nxt   = ST_OVERFLOW;
          phase_nxt = PH_SKIP;
          state_nxt = after;
        end else begin
          pal_re    = 1'b1;
          pal_raddr = start_r;
          ptr_nxt   = start_r + 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_SUITE;
        end
      end
      S_SUITE: begin
        if (can_take) begin
          push      = 1'b1;
          res.color = pal_rdata;
          res.rep   = 32'd1;
          res.start = pix_r;
          pix_nxt   = pix_r + 32'd1;
          if (cnt_r == depth_r) begin
            state_nxt = after;
          end else begin
            pal_re    = 1'b1;
            pal_raddr = ptr_r;
            ptr_nxt   = ptr_r + 1'b1;
            cnt_nxt   = cnt_r + 7'd1;
          end
        end
      end
      S_STAT: begin
        if (can_take) begin
          push          = 1'b1;
          res.start     = pix_r;
          res.is_status = 1'b1;
          res.last      = 1'b1;
          if (err_r != ST_OK) begin
            res.code = err_r;
          end else if (phase_r != PH_HEADER || pix_r != total) begin
            res.code = ST_SHORT;
          end else begin
            res.code = ST_OK;
          end
          size_nxt  = '0;
          phase_nxt = PH_COUNT;
          pos_nxt   = 2'd0;
          hdr_nxt   = '0;
          run_nxt   = '0;
          pix_nxt   = '0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_COUNT;
      size_r  <= '0;
      nb_r    <= 3'd1;
      idx_r   <= '0;
      sub_r   <= 2'd0;
      hdr_r   <= '0;
      pos_r   <= 2'd0;
      run_r   <= '0;
      pix_r   <= '0;
      err_r   <= ST_OK;
      last_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      size_r  <= size_nxt;
      nb_r    <= nb_nxt;
      idx_r   <= idx_nxt;
      sub_r   <= sub_nxt;
      hdr_r   <= hdr_nxt;
      pos_r   <= pos_nxt;
      run_r   <= run_nxt;
      pix_r   <= pix_nxt;
      err_r   <= err_nxt;
      last_r  <= last_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blue_r  <= blue_nxt;
    green_r <= green_nxt;
    start_r <= start_nxt;
    ptr_r   <= ptr_nxt;
    depth_r <= depth_nxt;
  end

endmodule

FILE: design/palette_run_suite_decoder_core.sv
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  tdata: data_byte; tlast: last_byte
// out_     out  out_tvalid/out_tready tdata: pixel_color, repeat_count,
//                                     start_index, status_code; tuser: is_status;
//                                     tlast: last_result
// cfg_     in   cfg_we               cfg_index, cfg_wdata
//
// Header, palette and run bytes are taken while the sequencer is idle.
// A byte that closes a segment passes through check, run item,
// suite check, then one palette RAM read per suite pixel (single read port).
// A closing status item ends the frame. No clearing pass after reset.
// Output stalls hold the sequencer only while the output register is full.
module palette_run_suite_decoder_core
  import prsd_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [23:0] pixel_color, [55:24] repeat_count,
                                  // [87:56] start_index, [90:88] status_code
  output logic        out_tuser,  // [0] is_status
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [15:0]   width_r, height_r;
  logic [31:0]   total_r;
  logic          pal_we, pal_re;
  logic [AW-1:0] pal_waddr, pal_raddr;
  logic [23:0]   pal_wdata, pal_rdata;
  logic          push, can_take;
  res_t          res, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd1;
      height_r <= 16'd1;
      total_r  <= 32'd1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  width_r  <= cfg_wdata;
          REG_HEIGHT: height_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      total_r <= {16'd0, width_r} * {16'd0, height_r};
    end
  end

  prsd_ctrl #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .AW(AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .total    (total_r),
    .pal_we   (pal_we),
    .pal_waddr(pal_waddr),
    .pal_wdata(pal_wdata),
    .pal_re   (pal_re),
    .pal_raddr(pal_raddr),
    .pal_rdata(pal_rdata),
    .push     (push),
    .res      (res),
    .can_take (can_take)
  );

  prsd_pal_ram #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .AW(AW)
  ) u_ram (
    .clk    (clk),
    .we     (pal_we),
    .waddr  (pal_waddr),
    .wdata  (pal_wdata),
    .re     (pal_re),
    .raddr  (pal_raddr),
    .rdata_r(pal_rdata)
  );

  prsd_out_buf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .res      (res),
    .can_take (can_take),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tdata = {5'd0, out_res.code, out_res.start, out_res.rep, out_res.color};
  assign out_tuser = out_res.is_status;
  assign out_tlast = out_res.last;

endmodule

FILE: design/prsd_checker.sv
module prsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [15:0] cfg_wdata
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output item changed");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == out_tuser)
    else $error("last flag not on the status item alone");

  a_status_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[55:0] == 56'd0)
    else $error("status item carries color or count");

  a_pixel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[90:88] == 3'd0)
    else $error("pixel item with nonzero status code");

endmodule

bind palette_run_suite_decoder_core prsd_checker u_chk (.*);
